/* hw/rtl/mcoc_pkg.sv */
// ----------------------------------------------------------------------------
// mcoc_pkg
// shared widths, sequencer states and datapath control for the chain-order
// cost block
// ----------------------------------------------------------------------------
package mcoc_pkg;

  localparam int DIM_FIELD_W = 16;   // width of the rows / cols fields
  localparam int COST_W      = 52;   // width of a cost value
  localparam int SPLIT_W     = 4;    // width of the reported split index

  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE,   // taking matrices
    S_CELL,   // read rows(i) and cols(j) of the next table cell
    S_LOAD,   // latch rows(i), cols(j)
    S_RD,     // read rows(k+1) and the two sub-chain costs
    S_M1,     // rows(i) * rows(k+1)
    S_M2,     // previous product * cols(j), add sub-chain costs
    S_ACC,    // total, compare against best so far
    S_WR      // store best cost of the cell
  } mcoc_state_t;

  typedef struct packed {
    logic mul_en;     // load product register
    logic mul_first;  // first multiply of a split (rows by rows)
    logic sum_en;     // load sub-chain cost sum
    logic acc_en;     // compare candidate and update best
    logic acc_first;  // first split of the cell, always taken
  } mcoc_ctl_t;

endpackage

/* hw/rtl/mcoc_if.sv */
// ----------------------------------------------------------------------------
// mcoc_in_if / mcoc_out_if
// valid/ready channels for matrices in and chain results out
// ----------------------------------------------------------------------------
interface mcoc_in_if;
  logic                               valid;
  logic                               ready;
  logic [mcoc_pkg::DIM_FIELD_W-1:0]   rows;
  logic [mcoc_pkg::DIM_FIELD_W-1:0]   cols;
  logic                               last;

  modport source (output valid, rows, cols, last, input ready);
  modport sink   (input valid, rows, cols, last, output ready);
endinterface

interface mcoc_out_if;
  logic                               valid;
  logic                               ready;
  logic [mcoc_pkg::COST_W-1:0]        min_cost;
  logic [mcoc_pkg::SPLIT_W-1:0]       top_split;
  logic                               too_many;

  modport source (output valid, min_cost, top_split, too_many, input ready);
  modport sink   (input valid, min_cost, top_split, too_many, output ready);
endinterface

/* hw/rtl/matrix_chain_order_cost_core.sv */
// ----------------------------------------------------------------------------
// matrix_chain_order_cost_core
// minimum scalar multiplication count of a matrix chain and its top split
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries one matrix per transfer (rows, cols, last). matrices are
//   stored in order; the transfer with last set closes the chain.
//   out_ch carries one result per chain: min_cost, top_split, too_many.
//   a chain of one matrix, or one that ran past MAX_MATRICES, answers in
//   the cycle after its last transfer (cost 0, too_many set on overflow).
//   for n matrices the cost table is filled cell by cell, each split
//   in turn on a single shared multiplier. in_ch is not ready while a
//   chain is solved.
//   reset (rst_n low, synchronous) empties the chain and drops any pending
//   result; stored dims and costs are not cleared, they are always written
//   before being read.
//   a stalled out_ch holds its result and in_ch is not ready meanwhile; a
//   transfer is taken again in the cycle the result leaves.
// ----------------------------------------------------------------------------
module matrix_chain_order_cost_core #(
  parameter int MAX_MATRICES = 16,
  parameter int DIM_BITS     = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  mcoc_in_if.sink     in_ch,
  mcoc_out_if.source  out_ch
);

  import mcoc_pkg::*;

  // stored dim width: the field width further limited by DIM_BITS
  localparam int SW    = (DIM_BITS < DIM_FIELD_W) ? DIM_BITS : DIM_FIELD_W;
  localparam int IDX_W = (MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1;
  localparam int LEN_W = $clog2(MAX_MATRICES + 1);

  // sequencer
  mcoc_state_t state_r, state_nxt;

  // chain bookkeeping
  logic [LEN_W-1:0] len_r;
  logic             ovf_r;
  logic [IDX_W-1:0] nm1_r;     // index of the last matrix in the chain

  // table walk: cell (i, j = i + span), split k
  logic [IDX_W-1:0] span_r;
  logic [IDX_W-1:0] i_r;
  logic [IDX_W-1:0] k_r;
  logic [IDX_W-1:0] best_k_r;
  logic [IDX_W-1:0] j;
  logic [IDX_W-1:0] k1;

  // operands of the current cell / split
  logic [SW-1:0]     ri_r;
  logic [SW-1:0]     cj_r;
  logic              za_r;     // left sub-chain is a single matrix
  logic              zb_r;     // right sub-chain is a single matrix

  // memories
  logic [SW-1:0]     row_q;
  logic [SW-1:0]     col_q;
  logic              dim_rd_en;
  logic [IDX_W-1:0]  dim_row_addr;
  logic [COST_W-1:0] cost_a_q;
  logic [COST_W-1:0] cost_b_q;
  logic [COST_W-1:0] ca;
  logic [COST_W-1:0] cb;
  logic              cost_rd_en;
  logic              cost_we;

  // shared unit
  mcoc_ctl_t         ctl;
  logic [COST_W-1:0] best;
  logic              take;

  // input side
  logic              in_fire;
  logic              store;
  logic [LEN_W-1:0]  len_after;
  logic              ovf_after;
  logic              start_solve;

  // result register
  logic              out_valid_r;
  logic [COST_W-1:0] out_cost_r;
  logic [SPLIT_W-1:0] out_split_r;
  logic              out_many_r;
  logic              out_fire;
  logic              res_set;
  logic [COST_W-1:0] res_cost;
  logic [SPLIT_W-1:0] res_split;
  logic              res_many;
  logic [IDX_W+SPLIT_W-1:0] best_k_ext;
  logic              last_cell;

  assign j  = i_r + span_r;
  assign k1 = k_r + IDX_W'(1);

  // ---------------------------------------------------------------- input
  // a closing transfer needs the result register free (or freeing now)
  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign store       = (len_r < LEN_W'(MAX_MATRICES));
  assign len_after   = store ? (len_r + LEN_W'(1)) : len_r;
  assign ovf_after   = ovf_r || !store;
  assign start_solve = in_fire && in_ch.last && !ovf_after && (len_after > LEN_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      ovf_r <= 1'b0;
    end else if (in_fire) begin
      if (in_ch.last) begin
        len_r <= '0;
        ovf_r <= 1'b0;
      end else begin
        len_r <= len_after;
        ovf_r <= ovf_after;
      end
    end
  end

  // --------------------------------------------------------------- storage
  assign dim_row_addr = (state_r == S_RD) ? k1 : i_r;

  mcoc_dim_mem #(
    .DEPTH (MAX_MATRICES),
    .AW    (IDX_W),
    .DW    (SW)
  ) u_dim_mem (
    .clk      (clk),
    .we       (in_fire && store),
    .waddr    (len_r[IDX_W-1:0]),
    .wrow     (in_ch.rows[SW-1:0]),
    .wcol     (in_ch.cols[SW-1:0]),
    .rd_en    (dim_rd_en),
    .row_addr (dim_row_addr),
    .col_addr (j),
    .row_q    (row_q),
    .col_q    (col_q)
  );

  mcoc_cost_mem #(
    .DEPTH (MAX_MATRICES),
    .AW    (IDX_W)
  ) u_cost_mem (
    .clk   (clk),
    .we    (cost_we),
    .wi    (i_r),
    .wj    (j),
    .wdata (best),
    .rd_en (cost_rd_en),
    .ai    (i_r),
    .aj    (k_r),
    .bi    (k1),
    .bj    (j),
    .a_q   (cost_a_q),
    .b_q   (cost_b_q)
  );

  // single-matrix sub-chains cost nothing and are never written
  assign ca = za_r ? '0 : cost_a_q;
  assign cb = zb_r ? '0 : cost_b_q;

  mcoc_unit #(
    .SW (SW)
  ) u_unit (
    .clk  (clk),
    .ctl  (ctl),
    .ri   (ri_r),
    .rk   (row_q),
    .cj   (cj_r),
    .ca   (ca),
    .cb   (cb),
    .best (best),
    .take (take)
  );

  // ------------------------------------------------------------- sequencer
  assign last_cell = (i_r == '0) && (j == nm1_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start_solve) state_nxt = S_CELL;
      S_CELL: state_nxt = S_LOAD;
      S_LOAD: state_nxt = S_RD;
      S_RD:   state_nxt = S_M1;
      S_M1:   state_nxt = S_M2;
      S_M2:   state_nxt = S_ACC;
      S_ACC:  state_nxt = (k1 == j) ? S_WR : S_RD;
      S_WR:   state_nxt = last_cell ? S_IDLE : S_CELL;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl        = '0;
    dim_rd_en  = 1'b0;
    cost_rd_en = 1'b0;
    cost_we    = 1'b0;
    unique case (state_r)
      S_CELL: dim_rd_en = 1'b1;
      S_RD: begin
        dim_rd_en  = 1'b1;
        cost_rd_en = 1'b1;
      end
      S_M1: begin
        ctl.mul_en    = 1'b1;
        ctl.mul_first = 1'b1;
      end
      S_M2: begin
        ctl.mul_en = 1'b1;
        ctl.sum_en = 1'b1;
      end
      S_ACC: begin
        ctl.acc_en    = 1'b1;
        ctl.acc_first = (k_r == i_r);
      end
      S_WR: cost_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // table walk counters: span outer, first matrix inner, split innermost
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_r <= '0;
      i_r    <= '0;
      k_r    <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: if (start_solve) begin
          span_r <= IDX_W'(1);
          i_r    <= '0;
        end
        S_CELL: k_r <= i_r;
        S_ACC:  k_r <= k1;
        S_WR: if (j == nm1_r) begin
          span_r <= span_r + IDX_W'(1);
          i_r    <= '0;
        end else begin
          i_r <= i_r + IDX_W'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start_solve) begin
      nm1_r <= IDX_W'(len_after - LEN_W'(1));
    end
    if (state_r == S_LOAD) begin
      ri_r <= row_q;
      cj_r <= col_q;
    end
    if (state_r == S_RD) begin
      za_r <= (k_r == i_r);
      zb_r <= (k1 == j);
    end
    // strict less-than in the unit keeps the lowest split on ties
    if (ctl.acc_en && take) begin
      best_k_r <= k_r;
    end
  end

  // ---------------------------------------------------------------- result
  assign best_k_ext = {{SPLIT_W{1'b0}}, best_k_r};

  always_comb begin
    res_set   = 1'b0;
    res_cost  = '0;
    res_split = '0;
    res_many  = 1'b0;
    if (in_fire && in_ch.last && !start_solve) begin
      res_set  = 1'b1;
      res_many = ovf_after;
    end else if (state_r == S_WR && last_cell) begin
      res_set   = 1'b1;
      res_cost  = best;
      res_split = best_k_ext[SPLIT_W-1:0];
    end
  end

  assign out_fire = out_valid_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_set) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_set) begin
      out_cost_r  <= res_cost;
      out_split_r <= res_split;
      out_many_r  <= res_many;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.min_cost  = out_cost_r;
  assign out_ch.top_split = out_split_r;
  assign out_ch.too_many  = out_many_r;

endmodule

/* hw/rtl/mcoc_dim_mem.sv */
// ----------------------------------------------------------------------------
// mcoc_dim_mem
// row and column counts of the stored chain, one write port, registered reads
// ----------------------------------------------------------------------------
module mcoc_dim_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wrow,
  input  logic [DW-1:0] wcol,
  input  logic          rd_en,
  input  logic [AW-1:0] row_addr,
  input  logic [AW-1:0] col_addr,
  output logic [DW-1:0] row_q,
  output logic [DW-1:0] col_q
);

  logic [DW-1:0] row_mem [DEPTH];
  logic [DW-1:0] col_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      row_mem[waddr] <= wrow;
      col_mem[waddr] <= wcol;
    end
    if (rd_en) begin
      row_q <= row_mem[row_addr];
      col_q <= col_mem[col_addr];
    end
  end

endmodule

/* hw/rtl/mcoc_cost_mem.sv */
// ----------------------------------------------------------------------------
// mcoc_cost_mem
// sub-chain cost table indexed by (first, last) matrix, two registered reads
// ----------------------------------------------------------------------------
module mcoc_cost_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                wi,
  input  logic [AW-1:0]                wj,
  input  logic [mcoc_pkg::COST_W-1:0]  wdata,
  input  logic                         rd_en,
  input  logic [AW-1:0]                ai,
  input  logic [AW-1:0]                aj,
  input  logic [AW-1:0]                bi,
  input  logic [AW-1:0]                bj,
  output logic [mcoc_pkg::COST_W-1:0]  a_q,
  output logic [mcoc_pkg::COST_W-1:0]  b_q
);

  import mcoc_pkg::*;

  logic [COST_W-1:0] mem [DEPTH][DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wi][wj] <= wdata;
    end
    if (rd_en) begin
      a_q <= mem[ai][aj];
      b_q <= mem[bi][bj];
    end
  end

endmodule

/* hw/rtl/mcoc_unit.sv */
// ----------------------------------------------------------------------------
// mcoc_unit
// shared multiplier, saturating adders and running minimum of one table cell
// ----------------------------------------------------------------------------
module mcoc_unit #(
  parameter int SW = 16
) (
  input  logic                         clk,
  input  mcoc_pkg::mcoc_ctl_t          ctl,
  input  logic [SW-1:0]                ri,
  input  logic [SW-1:0]                rk,
  input  logic [SW-1:0]                cj,
  input  logic [mcoc_pkg::COST_W-1:0]  ca,
  input  logic [mcoc_pkg::COST_W-1:0]  cb,
  output logic [mcoc_pkg::COST_W-1:0]  best,
  output logic                         take
);

  import mcoc_pkg::*;

  logic [3*SW-1:0]   p_r;
  logic [2*SW-1:0]   mul_a;
  logic [SW-1:0]     mul_b;
  logic [3*SW-1:0]   prod;
  logic [COST_W:0]   sum_ab;
  logic [COST_W-1:0] sum_r;
  logic [COST_W:0]   cand_wide;
  logic [COST_W-1:0] cand;
  logic [COST_W-1:0] best_r;

  // one multiplier, used twice per split
  always_comb begin
    mul_a = ctl.mul_first ? {{SW{1'b0}}, ri} : p_r[2*SW-1:0];
    mul_b = ctl.mul_first ? rk : cj;
    prod  = (3*SW)'(mul_a) * (3*SW)'(mul_b);
  end

  // product of three dims fits in 3*SW <= 48 bits, only the sums saturate
  always_comb begin
    sum_ab    = {1'b0, ca} + {1'b0, cb};
    cand_wide = {1'b0, sum_r} + (COST_W+1)'(p_r);
    cand      = cand_wide[COST_W] ? COST_MAX : cand_wide[COST_W-1:0];
    take      = ctl.acc_first || (cand < best_r);
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      p_r <= prod;
    end
    if (ctl.sum_en) begin
      sum_r <= sum_ab[COST_W] ? COST_MAX : sum_ab[COST_W-1:0];
    end
    if (ctl.acc_en && take) begin
      best_r <= cand;
    end
  end

  assign best = best_r;

endmodule
